FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the decoder.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/ucdw_pkg.sv
// Shared types, constants and decode functions of the UTF-8 width decoder.
// Depends on nothing; used by every module of the block.
package ucdw_pkg;

   localparam int WIDTH_BITS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Most code points one byte can release
   localparam int MAX_RUN = 4;
   localparam int IDX_W   = $clog2(MAX_RUN);
   localparam int NUM_W   = $clog2(MAX_RUN + 1);

   localparam logic [20:0] REPL_CHAR       = 21'h00FFFD;
   localparam logic [20:0] MAX_SCALAR      = 21'h10FFFF;
   localparam logic [20:0] SURR_LO         = 21'h00D800;
   localparam logic [20:0] SURR_HI         = 21'h00DFFF;
   localparam logic [15:0] MAX_WIDTH_RESET = 16'hFFFF;

   // One decoded code point
   typedef struct packed {
      logic [20:0] cp;
      logic [2:0]  used;
      logic        ok;
      logic [1:0]  cols;
   } decode_type;

   // Everything one accepted byte releases
   typedef struct packed {
      decode_type [MAX_RUN-1:0] res;
      logic [NUM_W-1:0]         num;
      logic                     at_end;
   } group_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic valid;
   } q_status_type;

   function automatic logic in_rng(input logic [20:0] v, input logic [20:0] lo,
                                   input logic [20:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if (b < 8'h80)                      len = 3'd1;
      else if (b >= 8'hF0 && b <= 8'hF4)  len = 3'd4;
      else if (b >= 8'hE0 && b <= 8'hEF)  len = 3'd3;
      else if (b >= 8'hC2 && b <= 8'hDF)  len = 3'd2;
      return len;
   endfunction

   function automatic logic [1:0] columns_of(input logic [20:0] v);
      logic zero_w;
      logic wide;
      logic [1:0] cols;
      zero_w = (v < 21'h20) || (v >= 21'h7F && v < 21'hA0) ||
               in_rng(v, 21'h0300, 21'h036F) || in_rng(v, 21'h1AB0, 21'h1AFF) ||
               in_rng(v, 21'h1DC0, 21'h1DFF) || in_rng(v, 21'h20D0, 21'h20FF) ||
               in_rng(v, 21'hFE20, 21'hFE2F) || (v == 21'h200D) ||
               in_rng(v, 21'hFE00, 21'hFE0F);
      wide   = in_rng(v, 21'h1100, 21'h115F) || in_rng(v, 21'h2329, 21'h232A) ||
               in_rng(v, 21'h2E80, 21'hA4CF) || in_rng(v, 21'hAC00, 21'hD7A3) ||
               in_rng(v, 21'hF900, 21'hFAFF) || in_rng(v, 21'hFE10, 21'hFE19) ||
               in_rng(v, 21'hFE30, 21'hFE6F) || in_rng(v, 21'hFF00, 21'hFF60) ||
               in_rng(v, 21'hFFE0, 21'hFFE6) || in_rng(v, 21'h1F300, 21'h1FAFF) ||
               in_rng(v, 21'h20000, 21'h3FFFD);
      if (zero_w)    cols = 2'd0;
      else if (wide) cols = 2'd2;
      else           cols = 2'd1;
      return cols;
   endfunction

   // Decode the sequence that opens at b0; used of zero means wait for more
   function automatic decode_type decode_front(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2, input logic [7:0] b3,
                                               input logic [2:0] avail, input logic at_end);
      decode_type d;
      logic [2:0]  len;
      logic [20:0] acc;
      logic        cont_ok;
      logic        bad;
      d.cp   = REPL_CHAR;
      d.ok   = 1'b0;
      d.used = 3'd1;
      len    = lead_length(b0);
      acc    = '0;
      cont_ok = 1'b0;
      bad     = 1'b1;
      if (len == 3'd1) begin
         d.cp = {13'd0, b0};
         d.ok = 1'b1;
      end else if (len != 3'd0 && len > avail) begin
         d.used = at_end ? 3'd1 : 3'd0;
      end else if (len != 3'd0) begin
         case (len)
            3'd2: begin
               acc     = {10'd0, b0[4:0], b1[5:0]};
               cont_ok = (b1[7:6] == 2'b10);
               bad     = (acc < 21'h80);
            end
            3'd3: begin
               acc     = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
               cont_ok = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10);
               bad     = (acc < 21'h800);
            end
            default: begin
               acc     = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
               cont_ok = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10) && (b3[7:6] == 2'b10);
               bad     = (acc < 21'h10000) || (acc > MAX_SCALAR);
            end
         endcase
         if (in_rng(acc, SURR_LO, SURR_HI)) bad = 1'b1;
         if (cont_ok && !bad) begin
            d.cp   = acc;
            d.ok   = 1'b1;
            d.used = len;
         end
      end
      d.cols = columns_of(d.cp);
      return d;
   endfunction

endpackage

FILE: sv/utf8_decode_display_width_unit.sv
// UTF-8 decoder with display width. A byte is taken each cycle while the
// group queue has room; its group is written into the queue, and the back
// end moves its code points from the queue head into the result register,
// where each can be popped. The back end issues one code point per cycle
// unless the result waits; a byte releases 0 to 4 code points.
// Synchronous reset clears held bytes, queue, running width and result
// register, and sets max_width to 65535.
module utf8_decode_display_width_unit #(
   parameter int WIDTH_BITS  = ucdw_pkg::WIDTH_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = ucdw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_byte_in,
   input  logic        req_end_of_text,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [20:0] rsp_scalar,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_valid_res,
   output logic [1:0]  rsp_column_width,
   output logic [15:0] rsp_total_width,
   output logic        rsp_within_limit,
   output logic        rsp_run_last,
   output logic        rsp_string_last,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import ucdw_pkg::*;

   logic [15:0]  max_width_ff;
   logic         q_push;
   logic         q_pop;
   group_type    q_in;
   group_type    q_head;
   q_status_type q_status;

   // Hold the column limit
   always_ff @(posedge clock) begin
      if (reset) begin
         max_width_ff <= MAX_WIDTH_RESET;
      end else if (csr_wr_en) begin
         max_width_ff <= csr_wr_data;
      end
   end

   ucdw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_byte_in     (req_byte_in),
      .req_end_of_text (req_end_of_text),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_data          (q_in)
   );

   ucdw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head_data (q_head),
      .status    (q_status)
   );

   ucdw_back #(
      .WIDTH_BITS (WIDTH_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .max_width        (max_width_ff),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_scalar       (rsp_scalar),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_column_width (rsp_column_width),
      .rsp_total_width  (rsp_total_width),
      .rsp_within_limit (rsp_within_limit),
      .rsp_run_last     (rsp_run_last),
      .rsp_string_last  (rsp_string_last)
   );

endmodule

FILE: sv/ucdw_front.sv
// Front end: accepts bytes, holds an incomplete sequence and decodes it.
// Depends on ucdw_pkg; feeds ucdw_queue one group per byte that yields code points.
module ucdw_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [7:0]           req_byte_in,
   input  logic                 req_end_of_text,
   input  ucdw_pkg::q_status_type q_status,
   output logic                 q_push,
   output ucdw_pkg::group_type  q_data
);
   import ucdw_pkg::*;

   logic [7:0] pend_ff [3];
   logic [7:0] pend_in [3];
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic [7:0] win [7];
   logic [2:0] n;
   logic [2:0] pos;
   logic [2:0] left;
   logic       stop;
   logic       accept;
   decode_type dec [MAX_RUN];
   group_type  grp;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;
   assign n        = {1'b0, cnt_ff} + 3'd1;

   // Line up held bytes and the new byte, zero padded past the end
   always_comb begin
      for (int i = 0; i < 7; i++) begin
         win[i] = 8'h00;
         if (i == int'(cnt_ff)) win[i] = req_byte_in;
      end
      for (int i = 0; i < 3; i++) begin
         if (i < int'(cnt_ff)) win[i] = pend_ff[i];
      end
   end

   // Decode at every start position side by side
   always_comb begin
      for (int p = 0; p < MAX_RUN; p++) begin
         dec[p] = decode_front(win[p], win[p+1], win[p+2], win[p+3], n - 3'(p),
                               req_end_of_text);
      end
   end

   // Walk the positions and collect the code points in order
   always_comb begin
      pos  = 3'd0;
      stop = 1'b0;
      grp  = '0;
      grp.at_end = req_end_of_text;
      for (int k = 0; k < MAX_RUN; k++) begin
         if (!stop && pos < n) begin
            if (dec[pos[1:0]].used == 3'd0) begin
               stop = 1'b1;
            end else begin
               grp.res[k] = dec[pos[1:0]];
               grp.num    = grp.num + NUM_W'(1);
               pos        = pos + dec[pos[1:0]].used;
            end
         end
      end
      left = n - pos;
   end

   // Keep what is still incomplete; drop all at end of text
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pend_in[i] = win[pos + 3'(i)];
      end
      cnt_in = req_end_of_text ? 2'd0 : left[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) pend_ff[i] <= pend_in[i];
      end
   end

   assign q_push = accept && (grp.num != '0);
   assign q_data = grp;

endmodule

FILE: sv/ucdw_queue.sv
// Short queue of decoded groups between front end and width back end.
// Depends on ucdw_pkg for the group and status types.
module ucdw_queue #(
   parameter int DEPTH = ucdw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ucdw_pkg::group_type   push_data,
   input  logic                  pop,
   output ucdw_pkg::group_type   head_data,
   output ucdw_pkg::q_status_type status
);
   import ucdw_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   group_type      slot_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff;
   logic [PW-1:0]  rd_ptr_ff;
   logic [CW-1:0]  count_ff;
   logic           do_push;
   logic           do_pop;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.valid = (count_ff != '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign head_data    = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         if (do_pop)  rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         if (do_push && !do_pop)      count_ff <= count_ff + CW'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CW'(1);
      end
   end

   // Store the incoming group
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: sv/ucdw_back.sv
// Back end: issues one code point per cycle unless the result waits;
// keeps running width, prefix flag, result register. Uses ucdw_pkg.
module ucdw_back #(
   parameter int WIDTH_BITS = ucdw_pkg::WIDTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ucdw_pkg::q_status_type q_status,
   input  ucdw_pkg::group_type    q_head,
   output logic                   q_pop,
   input  logic [15:0]            max_width,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [20:0]            rsp_scalar,
   output logic [2:0]             rsp_byte_count,
   output logic                   rsp_valid_res,
   output logic [1:0]             rsp_column_width,
   output logic [15:0]            rsp_total_width,
   output logic                   rsp_within_limit,
   output logic                   rsp_run_last,
   output logic                   rsp_string_last
);
   import ucdw_pkg::*;

   localparam int SW = WIDTH_BITS + 17;

   logic [IDX_W-1:0]      idx_ff;
   logic [WIDTH_BITS-1:0] sum_ff;
   logic                  limit_ff;
   logic                  out_valid_ff;
   logic [20:0]           cp_ff;
   logic [2:0]            used_ff;
   logic                  ok_ff;
   logic [1:0]            cols_ff;
   logic [15:0]           total_ff;
   logic                  within_ff;
   logic                  run_last_ff;
   logic                  str_last_ff;

   decode_type            cur;
   logic                  emit;
   logic                  last_in_group;
   logic                  str_end;
   logic [WIDTH_BITS:0]   sum_add;
   logic [WIDTH_BITS-1:0] sum_in;
   logic [SW-1:0]         sum_wide;
   logic                  limit_in;
   logic [WIDTH_BITS+15:0] sum_pad;

   assign cur           = q_head.res[idx_ff];
   assign emit          = q_status.valid && (!out_valid_ff || rsp_pop);
   assign last_in_group = ((NUM_W'(idx_ff) + NUM_W'(1)) == q_head.num);
   assign str_end       = last_in_group && q_head.at_end;
   assign q_pop         = emit && last_in_group;

   // Add this code point's columns, saturate, check against the limit
   always_comb begin
      sum_add  = {1'b0, sum_ff} + {{(WIDTH_BITS-1){1'b0}}, cur.cols};
      sum_in   = sum_add[WIDTH_BITS] ? '1 : sum_add[WIDTH_BITS-1:0];
      sum_wide = {17'd0, sum_ff} + {{(SW-2){1'b0}}, cur.cols};
      limit_in = limit_ff ||
                 ((cur.cols != 2'd0) && (sum_wide > {{(WIDTH_BITS+1){1'b0}}, max_width}));
      sum_pad  = {16'd0, sum_in};
   end

   // Step through the head group; clear running state at end of text
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         sum_ff   <= '0;
         limit_ff <= 1'b0;
      end else if (emit) begin
         idx_ff   <= last_in_group ? '0 : idx_ff + IDX_W'(1);
         sum_ff   <= str_end ? '0 : sum_in;
         limit_ff <= str_end ? 1'b0 : limit_in;
      end
   end

   // Result register: load on emit, drop on pop
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         cp_ff       <= cur.cp;
         used_ff     <= cur.used;
         ok_ff       <= cur.ok;
         cols_ff     <= cur.cols;
         total_ff    <= sum_pad[15:0];
         within_ff   <= !limit_in;
         run_last_ff <= last_in_group;
         str_last_ff <= str_end;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_scalar       = cp_ff;
   assign rsp_byte_count   = used_ff;
   assign rsp_valid_res    = ok_ff;
   assign rsp_column_width = cols_ff;
   assign rsp_total_width  = total_ff;
   assign rsp_within_limit = within_ff;
   assign rsp_run_last     = run_last_ff;
   assign rsp_string_last  = str_last_ff;

endmodule

FILE: sv/ucdw_checker.sv
// Port-level checks for the UTF-8 width decoder, bound to the top level.
// Depends on ucdw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ucdw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [20:0] rsp_scalar,
   input logic [2:0]  rsp_byte_count,
   input logic        rsp_valid_res,
   input logic [1:0]  rsp_column_width,
   input logic [15:0] rsp_total_width,
   input logic        rsp_run_last,
   input logic        rsp_string_last
);
   import ucdw_pkg::*;

   // Nothing waits right after reset
   `ASSERT_CLK_NORST(a_reset_empty, clock, reset |=> rsp_empty, "result present after reset")

   // A waiting result holds until popped
   `ASSERT_CLK(a_hold, clock, reset,
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_scalar) && $stable(rsp_total_width)),
      "waiting result changed")

   // End of string closes the run of its byte too
   `ASSERT_CLK(a_str_run, clock, reset, (!rsp_empty && rsp_string_last) |-> rsp_run_last,
      "string_last without run_last")

   // Replacement always one byte, one column
   `ASSERT_CLK(a_repl, clock, reset,
      (!rsp_empty && !rsp_valid_res) |->
         (rsp_scalar == REPL_CHAR && rsp_byte_count == 3'd1 && rsp_column_width == 2'd1),
      "malformed replacement")

   // A good single byte is ASCII
   `ASSERT_CLK(a_ascii, clock, reset,
      (!rsp_empty && rsp_valid_res && rsp_byte_count == 3'd1) |-> (rsp_scalar < 21'h80),
      "one-byte code point above 7F")

endmodule

bind utf8_decode_display_width_unit ucdw_checker u_ucdw_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_scalar       (rsp_scalar),
   .rsp_byte_count   (rsp_byte_count),
   .rsp_valid_res    (rsp_valid_res),
   .rsp_column_width (rsp_column_width),
   .rsp_total_width  (rsp_total_width),
   .rsp_run_last     (rsp_run_last),
   .rsp_string_last  (rsp_string_last)
);
